// ===== sv/spo2_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package spo2_pkg;

	localparam int RAW_W      = 18;
	localparam int TIME_W     = 32;
	localparam int CFG_W      = 18;
	localparam int CFG_ADDR_W = 1;
	localparam int RATIO_W    = 24;
	localparam int FRAC_W     = 16;
	localparam int STEP_W     = $clog2(RATIO_W);
	localparam int SPO2_W     = 18;
	localparam int SQ_W       = 2 * RATIO_W;
	localparam int LIN_W      = RATIO_W + 12;
	localparam int T2_W       = SQ_W + 8;
	localparam int POLY_W     = 60;
	localparam int SCALE_SH   = 32;

	localparam int K0_CENTI   = 13268;
	localparam int K1_CENTI   = 3465;
	localparam int K2_CENTI   = 159;
	localparam int SPO2_LIMIT = 100000;

	localparam logic [CFG_ADDR_W-1:0] REG_FINGER_THRESHOLD = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_WARMUP_BEATS     = 1'd1;

	typedef struct packed {
		logic [RAW_W-1:0]  raw_red;
		logic [RAW_W-1:0]  raw_ir;
		logic [RAW_W-1:0]  filt_red;
		logic [RAW_W-1:0]  filt_ir;
		logic              beat;
		logic [TIME_W-1:0] time_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [SPO2_W-1:0] spo2_centi;
		logic [RATIO_W-1:0]       ratio_q16;
		logic                     valid_res;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MUL,
		S_DIV,
		S_POLY1,
		S_POLY2,
		S_POLY3,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic check;
		logic mul_step;
		logic div_init;
		logic div_step;
		logic poly1;
		logic poly2;
		logic poly3;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic emit_now;
		logic zero_div;
		logic mul_last;
		logic div_last;
	} status_t;

endpackage
`default_nettype wire

// ===== sv/spo2_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spo2_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	input  wire spo2_pkg::status_t sts,
	output spo2_pkg::cmd_t        cmd
);
	import spo2_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && sts.emit_now) state_nxt = S_CHECK;
			end
			S_CHECK:  state_nxt = sts.zero_div ? S_FINISH : S_MUL;
			S_MUL: begin
				if (sts.mul_last) state_nxt = S_DIV;
			end
			S_DIV: begin
				if (sts.div_last) state_nxt = S_POLY1;
			end
			S_POLY1:  state_nxt = S_POLY2;
			S_POLY2:  state_nxt = S_POLY3;
			S_POLY3:  state_nxt = S_FINISH;
			S_FINISH: begin
				if (out_free) state_nxt = S_IDLE;
			end
			default:  state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.accept = in_valid;
			S_CHECK:  cmd.check = 1'b1;
			S_MUL: begin
				cmd.mul_step = 1'b1;
				cmd.div_init = sts.mul_last;
			end
			S_DIV:    cmd.div_step = 1'b1;
			S_POLY1:  cmd.poly1 = 1'b1;
			S_POLY2:  cmd.poly2 = 1'b1;
			S_POLY3:  cmd.poly3 = 1'b1;
			S_FINISH: cmd.load_out = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== sv/spo2_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spo2_dp #(
	parameter int SAMPLE_BITS = 18,
	parameter int COUNT_BITS  = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [spo2_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire logic [spo2_pkg::CFG_W-1:0]          cfg_data,
	input  wire spo2_pkg::in_item_t                  in_data,
	input  wire spo2_pkg::cmd_t                      cmd,
	output spo2_pkg::status_t                        sts,
	output spo2_pkg::out_item_t                      out_data
);
	import spo2_pkg::*;

	localparam int TOTAL_W = SAMPLE_BITS + COUNT_BITS;
	localparam int PROD_W  = SAMPLE_BITS + TOTAL_W;
	localparam int SHIFT_IN = RATIO_W - FRAC_W;

	logic [RAW_W-1:0]       thresh_q;
	logic [15:0]            warmup_q;

	logic [SAMPLE_BITS-1:0] red_min_q, red_max_q, ir_min_q, ir_max_q;
	logic [TOTAL_W-1:0]     red_total_q, ir_total_q;
	logic [COUNT_BITS-1:0]  stat_count_q, beat_tally_q;
	logic                   stats_empty_q;
	logic [TIME_W-1:0]      last_beat_q;

	logic [PROD_W-1:0]      mc_red_q, mc_ir_q, acc_red_q, acc_ir_q;
	logic [SAMPLE_BITS-1:0] mp_red_q, mp_ir_q;
	logic [STEP_W-1:0]      step_q;
	logic                   res_ok_q;

	logic [PROD_W-1:0]      rem_q;
	logic [RATIO_W-1:0]     dlo_q, quo_q;
	logic                   sat_q;

	logic [SQ_W-1:0]        sq_q;
	logic [LIN_W-1:0]       lin_q;
	logic [T2_W-1:0]        t2_q;
	logic signed [POLY_W-1:0] v_q;

	out_item_t              out_q;

	logic [SAMPLE_BITS-1:0] fr, fi, red_ac, ir_ac;
	logic                   raw_ok, finger;
	logic [TIME_W-1:0]      gap;
	logic                   gap_ok, warm;
	logic [PROD_W-1:0]      acc_red_nx, acc_ir_nx;
	logic [PROD_W:0]        rem2, den_x;
	logic                   ge;
	logic [RATIO_W-1:0]     ratio;
	logic signed [POLY_W-1:0] v_sum;
	logic signed [POLY_W-SCALE_SH-1:0] s_raw;
	logic signed [SPO2_W-1:0] s_sat;

	assign fr      = SAMPLE_BITS'(in_data.filt_red);
	assign fi      = SAMPLE_BITS'(in_data.filt_ir);
	assign raw_ok  = (in_data.raw_red != '0) && (in_data.raw_ir != '0);
	assign finger  = in_data.raw_ir > thresh_q;
	assign gap     = in_data.time_ms - last_beat_q;
	assign gap_ok  = (gap != '0) && !gap[TIME_W-1];
	assign warm    = 32'(beat_tally_q) >= 32'(warmup_q);
	assign red_ac  = red_max_q - red_min_q;
	assign ir_ac   = ir_max_q - ir_min_q;

	assign sts.emit_now = raw_ok && finger && in_data.beat && gap_ok && warm;
	assign sts.zero_div = (stat_count_q == '0) || (red_total_q == '0) ||
		(ir_total_q == '0) || (ir_ac == '0);
	assign sts.mul_last = (step_q == STEP_W'(SAMPLE_BITS - 1));
	assign sts.div_last = (step_q == STEP_W'(RATIO_W - 1));

	// products including this step's partial product
	assign acc_red_nx = mp_red_q[0] ? acc_red_q + mc_red_q : acc_red_q;
	assign acc_ir_nx  = mp_ir_q[0] ? acc_ir_q + mc_ir_q : acc_ir_q;

	// restoring division step, one quotient bit a cycle
	assign den_x = {1'b0, acc_ir_q};
	assign rem2  = {rem_q, dlo_q[RATIO_W-1]};
	assign ge    = rem2 >= den_x;
	assign ratio = sat_q ? '1 : quo_q;

	// rounding bias folded in, so an arithmetic shift gives the result
	assign v_sum = $signed(POLY_W'(t2_q)) + $signed(POLY_W'(K0_CENTI) << SCALE_SH)
		+ $signed(POLY_W'(1) << (SCALE_SH - 1)) - $signed(POLY_W'(lin_q) << FRAC_W);
	assign s_raw = v_q[POLY_W-1:SCALE_SH];

	always_comb begin
		if (s_raw > $signed((POLY_W-SCALE_SH)'(SPO2_LIMIT)))
			s_sat = SPO2_W'(SPO2_LIMIT);
		else if (s_raw < -$signed((POLY_W-SCALE_SH)'(SPO2_LIMIT)))
			s_sat = -SPO2_W'(SPO2_LIMIT);
		else
			s_sat = SPO2_W'(s_raw);
	end

	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q      <= RAW_W'(50000);
			warmup_q      <= 16'd5;
			red_min_q     <= '0;
			red_max_q     <= '0;
			ir_min_q      <= '0;
			ir_max_q      <= '0;
			red_total_q   <= '0;
			ir_total_q    <= '0;
			stat_count_q  <= '0;
			stats_empty_q <= 1'b1;
			last_beat_q   <= '0;
			beat_tally_q  <= '0;
			step_q        <= '0;
			res_ok_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_FINGER_THRESHOLD: thresh_q <= cfg_data;
					REG_WARMUP_BEATS:     warmup_q <= cfg_data[15:0];
					default:              thresh_q <= thresh_q;
				endcase
			end
			if (cmd.accept && raw_ok) begin
				if (!finger) begin
					red_min_q     <= '0;
					red_max_q     <= '0;
					ir_min_q      <= '0;
					ir_max_q      <= '0;
					red_total_q   <= '0;
					ir_total_q    <= '0;
					stat_count_q  <= '0;
					stats_empty_q <= 1'b1;
				end else begin
					if (stats_empty_q) begin
						red_min_q <= fr;
						red_max_q <= fr;
						ir_min_q  <= fi;
						ir_max_q  <= fi;
						stats_empty_q <= 1'b0;
					end else begin
						if (fr < red_min_q) red_min_q <= fr;
						if (fr > red_max_q) red_max_q <= fr;
						if (fi < ir_min_q) ir_min_q <= fi;
						if (fi > ir_max_q) ir_max_q <= fi;
					end
					if (stat_count_q != '1) begin
						stat_count_q <= stat_count_q + 1'b1;
						red_total_q  <= red_total_q + TOTAL_W'(fr);
						ir_total_q   <= ir_total_q + TOTAL_W'(fi);
					end
					if (in_data.beat) begin
						last_beat_q <= in_data.time_ms;
						if (gap_ok && beat_tally_q != '1)
							beat_tally_q <= beat_tally_q + 1'b1;
					end
				end
			end
			if (cmd.check) begin
				res_ok_q      <= !sts.zero_div;
				step_q        <= '0;
				red_min_q     <= '0;
				red_max_q     <= '0;
				ir_min_q      <= '0;
				ir_max_q      <= '0;
				red_total_q   <= '0;
				ir_total_q    <= '0;
				stat_count_q  <= '0;
				stats_empty_q <= 1'b1;
			end
			if (cmd.div_init) step_q <= '0;
			else if (cmd.mul_step || cmd.div_step) step_q <= step_q + 1'b1;
		end
	end

	// operand capture, shift-add multiply, divide and polynomial
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			mc_red_q  <= PROD_W'(ir_total_q);
			mp_red_q  <= red_ac;
			mc_ir_q   <= PROD_W'(red_total_q);
			mp_ir_q   <= ir_ac;
			acc_red_q <= '0;
			acc_ir_q  <= '0;
		end
		if (cmd.mul_step) begin
			acc_red_q <= acc_red_nx;
			acc_ir_q  <= acc_ir_nx;
			mc_red_q <= mc_red_q << 1;
			mc_ir_q  <= mc_ir_q << 1;
			mp_red_q <= mp_red_q >> 1;
			mp_ir_q  <= mp_ir_q >> 1;
		end
		if (cmd.div_init) begin
			rem_q <= acc_red_nx >> SHIFT_IN;
			sat_q <= (acc_red_nx >> SHIFT_IN) >= acc_ir_nx;
			dlo_q <= {acc_red_nx[SHIFT_IN-1:0], {FRAC_W{1'b0}}};
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? PROD_W'(rem2 - den_x) : rem2[PROD_W-1:0];
			quo_q <= {quo_q[RATIO_W-2:0], ge};
			dlo_q <= dlo_q << 1;
		end
		if (cmd.poly1) begin
			sq_q  <= SQ_W'(ratio) * SQ_W'(ratio);
			lin_q <= LIN_W'(ratio) * LIN_W'(K1_CENTI);
		end
		if (cmd.poly2) t2_q <= T2_W'(sq_q) * T2_W'(K2_CENTI);
		if (cmd.poly3) v_q <= v_sum;
		if (cmd.load_out) begin
			if (res_ok_q) begin
				out_q.spo2_centi <= s_sat;
				out_q.ratio_q16  <= ratio;
				out_q.valid_res  <= 1'b1;
			end else begin
				out_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/spo2_ratio_estimator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// SpO2 ratio-of-ratios estimator. Items that do not produce a result are taken without
// leaving idle. A counted beat past the warm-up produces one result item: a check step,
// the shift-add multiplier forming both cross products, the restoring divider (one ratio
// bit per step), the polynomial steps and a load of the output register, which waits while
// the output stalls. A zero divisor found at the check goes straight to an all-zero result.
// One item is worked on at a time; a new item is taken while a finished result
// still waits in the output register.
module spo2_ratio_estimator #(
	parameter int SAMPLE_BITS = 18,
	parameter int COUNT_BITS  = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [spo2_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [spo2_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire spo2_pkg::in_item_t              in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output spo2_pkg::out_item_t                  out_data
);
	import spo2_pkg::*;

	cmd_t    cmd;
	status_t sts;

	spo2_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	spo2_dp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

// ===== tb/tb_spo2_ratio_estimator.sv =====
`timescale 1ns / 1ps
module tb_spo2_ratio_estimator;
	import spo2_pkg::*;

	localparam int COUNT_MAX = 65535;
	localparam int WATCHDOG  = 20000;

	typedef struct {
		in_item_t  d;
		bit        typed;
		out_item_t e;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;

	spo2_ratio_estimator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// copy of the block state
	logic [17:0] thr_q;
	logic [15:0] warmup_q;
	logic [17:0] red_lo, red_hi, ir_lo, ir_hi;
	logic [33:0] red_sum, ir_sum;
	logic [15:0] n_samples;
	bit          no_samples;
	logic [31:0] prev_beat;
	logic [15:0] beats_seen;

	out_item_t spo2_pending[$];
	row_t      steps[$];
	int errors, items_in, results_out, invalid_out, quiet_cycles;
	bit idle_on, finished;
	logic [31:0] now_ms;

	initial begin
		clk = 1'b0;
		forever begin
			#1 clk = 1'b1;
			#1 clk = 1'b0;
		end
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (!idle_on || p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void mismatch(string what, longint exp_v, longint act_v);
		errors++;
		if (errors <= 10)
			$display("mismatch %s: expected %0d got %0d", what, exp_v, act_v);
	endfunction

	function automatic void clear_window();
		red_lo = 0; red_hi = 0; ir_lo = 0; ir_hi = 0;
		red_sum = 0; ir_sum = 0; n_samples = 0; no_samples = 1;
	endfunction

	function automatic out_item_t spo2_from_q16(logic [23:0] ratio);
		out_item_t r;
		longint rr, v, s;
		rr = ratio;
		v = (longint'(K0_CENTI) <<< 32) + longint'(K2_CENTI) * rr * rr
			- ((longint'(K1_CENTI) * rr) <<< 16) + (longint'(1) <<< 31);
		s = v >>> 32;
		if (s > SPO2_LIMIT) s = SPO2_LIMIT;
		if (s < -SPO2_LIMIT) s = -SPO2_LIMIT;
		r.spo2_centi = s[17:0];
		r.ratio_q16 = ratio;
		r.valid_res = 1'b1;
		return r;
	endfunction

	// returns 1 when the item yields an SpO2 result
	function automatic bit estimate(in_item_t x, output out_item_t r);
		logic [31:0] dt;
		logic [17:0] red_ac, ir_ac;
		logic [127:0] num, den, q;
		r = '0;
		if (x.raw_red == 0 || x.raw_ir == 0) return 0;
		if (x.raw_ir <= thr_q) begin
			clear_window();
			return 0;
		end
		if (no_samples) begin
			red_lo = x.filt_red; red_hi = x.filt_red;
			ir_lo = x.filt_ir; ir_hi = x.filt_ir;
			no_samples = 0;
		end else begin
			if (x.filt_red < red_lo) red_lo = x.filt_red;
			if (x.filt_red > red_hi) red_hi = x.filt_red;
			if (x.filt_ir < ir_lo) ir_lo = x.filt_ir;
			if (x.filt_ir > ir_hi) ir_hi = x.filt_ir;
		end
		if (n_samples < COUNT_MAX) begin
			n_samples++;
			red_sum += x.filt_red;
			ir_sum += x.filt_ir;
		end
		if (!x.beat) return 0;
		dt = x.time_ms - prev_beat;
		prev_beat = x.time_ms;
		if (dt == 0 || dt[31]) return 0;
		if (beats_seen < warmup_q) begin
			beats_seen++;
			return 0;
		end
		if (beats_seen < COUNT_MAX) beats_seen++;
		red_ac = red_hi - red_lo;
		ir_ac = ir_hi - ir_lo;
		if (n_samples == 0 || red_sum == 0 || ir_sum == 0 || ir_ac == 0) begin
			clear_window();
			return 1;
		end
		num = (128'(red_ac) * 128'(ir_sum)) << FRAC_W;
		den = 128'(red_sum) * 128'(ir_ac);
		q = num / den;
		clear_window();
		r = spo2_from_q16(q > 128'hFFFFFF ? 24'hFFFFFF : q[23:0]);
		return 1;
	endfunction

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FINGER_THRESHOLD) thr_q = val;
		else warmup_q = val[15:0];
	endtask

	task automatic settle();
		while (spo2_pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic configure(logic [17:0] thr, logic [15:0] wu);
		settle();
		write_reg(REG_FINGER_THRESHOLD, thr);
		write_reg(REG_WARMUP_BEATS, {2'b0, wu});
	endtask

	// typed rows push their own expectation; the predictor still tracks state
	task automatic send(in_item_t x, bit typed = 0, out_item_t e = '0);
		out_item_t r;
		int g;
		in_valid <= 1'b1;
		in_data <= x;
		do @(posedge clk); while (in_stall);
		items_in++;
		if (estimate(x, r)) spo2_pending.push_back(typed ? e : r);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic in_item_t mk(int rr, int ri, int fr, int fi, bit b, logic [31:0] t);
		in_item_t x;
		x.raw_red = rr; x.raw_ir = ri; x.filt_red = fr; x.filt_ir = fi;
		x.beat = b; x.time_ms = t;
		return x;
	endfunction

	function automatic void add(in_item_t x, bit typed = 0, out_item_t e = '0);
		row_t s;
		s.d = x; s.typed = typed; s.e = e;
		steps.push_back(s);
	endfunction

	function automatic in_item_t random_item();
		in_item_t x;
		int p, base;
		p = $urandom_range(0, 99);
		x.raw_red = $urandom_range(1, 262143);
		x.raw_ir = (thr_q < 262143) ? $urandom_range(thr_q + 1, 262143) : 18'h3FFFF;
		base = $urandom_range(0, 250000);
		if ($urandom_range(0, 9) == 0) begin
			x.filt_red = $urandom; x.filt_ir = $urandom;
		end else begin
			x.filt_red = base + $urandom_range(0, 4000);
			x.filt_ir = base / 2 + $urandom_range(0, 8000);
		end
		x.beat = ($urandom_range(0, 5) == 0);
		now_ms += $urandom_range(1, 900);
		if (p < 4) x.raw_red = 0;
		else if (p < 8) x.raw_ir = 0;
		else if (p < 12) x.raw_ir = $urandom_range(0, thr_q);
		else if (p < 15) now_ms -= $urandom_range(0, 2000);
		else if (p < 17) now_ms = $urandom;
		x.time_ms = now_ms;
		return x;
	endfunction

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_out++;
			if (!out_data.valid_res) invalid_out++;
			if (spo2_pending.size() == 0) begin
				mismatch("unexpected result, spo2", 0, out_data.spo2_centi);
			end else begin
				e = spo2_pending.pop_front();
				if (out_data.spo2_centi !== e.spo2_centi)
					mismatch("spo2_centi", e.spo2_centi, out_data.spo2_centi);
				if (out_data.ratio_q16 !== e.ratio_q16)
					mismatch("ratio_q16", e.ratio_q16, out_data.ratio_q16);
				if (out_data.valid_res !== e.valid_res)
					mismatch("valid_res", e.valid_res, out_data.valid_res);
			end
		end
		if (!arst_n) out_stall <= 1'b0;
		else out_stall <= idle_on && ($urandom_range(0, 99) < (out_stall ? 70 : 25));
	end

	always @(posedge clk) begin
		if (!arst_n || finished || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("timeout with %0d results outstanding", spo2_pending.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		out_item_t zero_res;
		zero_res = '0;
		arst_n = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_data = '0;
		in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
		idle_on = 1; finished = 0; now_ms = 0;
		thr_q = 50000; warmup_q = 5; prev_beat = 0; beats_seen = 0;
		clear_window();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero raw samples are ignored, raw_ir at threshold means no finger
		add(mk(0, 60000, 500, 500, 1, 5));
		add(mk(60000, 0, 500, 500, 1, 5));
		add(mk(60000, 50000, 500, 500, 1, 5));
		// warm-up beats with flat signals, then an ir AC of zero
		for (int i = 1; i <= 5; i++) add(mk(60000, 60000, 1000, 1000, 1, 10 * i));
		add(mk(60000, 60000, 1000, 1000, 1, 60), 1, zero_res);
		add(mk(60000, 60000, 0, 7, 1, 60));
		add(mk(262143, 262143, 262143, 262143, 1, 50));
		add(mk(1, 262143, 0, 0, 0, 55));
		add(mk(60000, 60000, 131072, 100, 1, 70));
		add(mk(60000, 60000, 5, 1, 1, 32'hFFFF_FFFF));
		add(mk(60000, 60000, 900, 3, 0, 0));
		add(mk(60000, 60000, 20, 262143, 1, 5));
		// red sum of zero
		add(mk(60000, 60000, 0, 100, 0, 6));
		add(mk(60000, 60000, 0, 200, 1, 7), 1, zero_res);
		add(mk(60000, 60000, 30000, 70000, 0, 8));
		add(mk(60000, 60000, 31000, 69000, 1, 9));
		foreach (steps[i]) send(steps[i].d, steps[i].typed, steps[i].e);
		in_valid <= 1'b0;
		now_ms = 100;

		configure(0, 0);
		for (int i = 0; i < 400; i++) begin
			if (i % 100 == 0) idle_on = $urandom_range(0, 3) != 0;
			send(random_item());
		end
		in_valid <= 1'b0;
		idle_on = 1;
		configure(120000, 3);
		for (int i = 0; i < 500; i++) send(random_item());
		in_valid <= 1'b0;
		configure(262143, 65535);
		for (int i = 0; i < 100; i++) send(random_item());
		in_valid <= 1'b0;
		configure(0, 65535);
		for (int i = 0; i < 100; i++) send(random_item());
		in_valid <= 1'b0;
		configure(30000, 1);
		for (int i = 0; i < 500; i++) send(random_item());
		in_valid <= 1'b0;

		configure(50000, 5);
		for (int i = 0; i < 50; i++) send(random_item());
		in_valid <= 1'b0;

		settle();
		finished = 1;
		$display("sent %0d items over several threshold and warm-up settings", items_in);
		$display("checked %0d results, %0d of them flagged invalid", results_out, invalid_out);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/spo2_pkg.sv
sv/spo2_ctrl.sv
sv/spo2_dp.sv
sv/spo2_ratio_estimator.sv
tb/tb_spo2_ratio_estimator.sv
